/* hdl/hrlc_pkg.sv */
package hrlc_pkg;

  // Item payloads on the two channels.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_request;
  } hrlc_in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] method_kind;
  } hrlc_out_t;

  // Byte classes produced by the front end.
  typedef enum logic [1:0] {
    CLS_CHAR = 2'd0,
    CLS_SEP  = 2'd1,
    CLS_EOL  = 2'd2
  } hrlc_cls_t;

  // One queued, classified byte.
  typedef struct packed {
    logic [7:0] ch;
    hrlc_cls_t  cls;
    logic       last;
  } hrlc_entry_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic        valid;
    hrlc_entry_t entry;
  } hrlc_head_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Verdict codes.
  localparam logic [1:0] VERDICT_VALID   = 2'd0;
  localparam logic [1:0] VERDICT_BAD     = 2'd1;
  localparam logic [1:0] VERDICT_METHOD  = 2'd2;
  localparam logic [1:0] VERDICT_VERSION = 2'd3;

  // Method kinds.
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_POST    = 2'd2;
  localparam logic [1:0] KIND_DELETE  = 2'd3;

  // Word positions within the request line.
  localparam logic [1:0] WORD_METHOD  = 2'd0;
  localparam logic [1:0] WORD_PATH    = 2'd1;
  localparam logic [1:0] WORD_VERSION = 2'd2;
  localparam logic [1:0] WORD_EXTRA   = 2'd3;

  // Expected word lengths.
  localparam logic [3:0] LEN_GET     = 4'd3;
  localparam logic [3:0] LEN_POST    = 4'd4;
  localparam logic [3:0] LEN_DELETE  = 4'd6;
  localparam logic [3:0] LEN_VERSION = 4'd8;
  localparam logic [3:0] POS_MAX     = 4'd15;

  // Character matchers: true when c is the expected character at position p.
  function automatic logic get_char_ok(logic [3:0] p, logic [7:0] c);
    logic ok;
    case (p)
      4'd0:    ok = (c == "G");
      4'd1:    ok = (c == "E");
      4'd2:    ok = (c == "T");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic post_char_ok(logic [3:0] p, logic [7:0] c);
    logic ok;
    case (p)
      4'd0:    ok = (c == "P");
      4'd1:    ok = (c == "O");
      4'd2:    ok = (c == "S");
      4'd3:    ok = (c == "T");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic delete_char_ok(logic [3:0] p, logic [7:0] c);
    logic ok;
    case (p)
      4'd0:    ok = (c == "D");
      4'd1:    ok = (c == "E");
      4'd2:    ok = (c == "L");
      4'd3:    ok = (c == "E");
      4'd4:    ok = (c == "T");
      4'd5:    ok = (c == "E");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic version_char_ok(logic [3:0] p, logic [7:0] c);
    logic ok;
    case (p)
      4'd0:    ok = (c == "H");
      4'd1:    ok = (c == "T");
      4'd2:    ok = (c == "T");
      4'd3:    ok = (c == "P");
      4'd4:    ok = (c == "/");
      4'd5:    ok = (c == "1");
      4'd6:    ok = (c == ".");
      4'd7:    ok = (c == "1");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* hdl/http_request_line_checker.sv */
// Checks the first line of an HTTP request, fed one byte per transfer.
// Input channel: in_valid/in_ready with in_data (byte_in, end_of_request).
// Output channel: out_valid/out_ready with out_data (verdict, method_kind).
// Exactly one result follows each transfer that carries end_of_request.
// A front stage classifies each byte into a four-entry queue; the back stage
// scans one queued byte per cycle while the receiver does not stall, and forms
// the verdict in a result register. Throughput is one byte per cycle under
// that condition. A result is registered after its last byte leaves the queue.
// When the receiver stalls, the result stays in its register, and bytes keep
// flowing until a further last byte reaches the queue head; the queue then
// fills and in_ready drops once its four entries are taken.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and
// returns the scan state to the start of a request.
module http_request_line_checker import hrlc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hrlc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hrlc_out_t out_data
);

  hrlc_entry_t front_entry;
  hrlc_head_t  q_head;
  logic        q_take;

  // Byte classification.
  hrlc_front u_front (
    .in_data (in_data),
    .entry   (front_entry)
  );

  // Queue between the front and back stages.
  hrlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_entry (front_entry),
    .head     (q_head),
    .rd_take  (q_take)
  );

  // Line scan and verdict.
  hrlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .rd_take   (q_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A verdict taken from the queue is offered in the next cycle.
  a_verdict_offered: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_head.entry.last |=> out_valid)
    else $error("verdict not offered after last byte");

  // The back stage never takes from an empty queue.
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_head.valid)
    else $error("take from empty queue");

  // A last byte at the head waits while a result is stalled.
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    q_head.valid && q_head.entry.last && out_valid && !out_ready |-> !q_take)
    else $error("last byte taken while result stalled");

  // A valid verdict always names a recognized method.
  a_valid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == VERDICT_VALID |-> out_data.method_kind != KIND_UNKNOWN)
    else $error("valid verdict without method");
`endif

endmodule

/* hdl/hrlc_front.sv */
module hrlc_front import hrlc_pkg::*; (
  input  hrlc_in_t    in_data,
  output hrlc_entry_t entry
);

  // Sort each byte into line end, word separator or word character.
  always_comb begin
    entry.ch   = in_data.byte_in;
    entry.last = in_data.end_of_request;
    if (in_data.byte_in inside {8'h0A, 8'h00}) begin
      entry.cls = CLS_EOL;
    end else if (in_data.byte_in inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
      entry.cls = CLS_SEP;
    end else begin
      entry.cls = CLS_CHAR;
    end
  end

endmodule

/* hdl/hrlc_queue.sv */
module hrlc_queue import hrlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  hrlc_entry_t wr_entry,
  output hrlc_head_t  head,
  input  logic        rd_take
);

  hrlc_entry_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   push, pop;

  assign wr_ready   = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push       = wr_valid && wr_ready;
  assign pop        = rd_take && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];

  // Pointer and fill count update; both sides may move in one cycle.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

/* hdl/hrlc_back.sv */
module hrlc_back import hrlc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hrlc_head_t head,
  output logic       rd_take,
  output logic       out_valid,
  input  logic       out_ready,
  output hrlc_out_t  out_data
);

  typedef struct packed {
    logic       line_done;
    logic [1:0] word_index;
    logic       in_word;
    logic [3:0] char_pos;
    logic [2:0] method_candidates;
    logic       version_match;
    logic       path_first_ok;
    logic [7:0] path_prev_char;
    logic       path_bad_pair;
    logic [1:0] words_seen;
  } scan_t;

  function automatic scan_t scan_reset();
    scan_t s;
    s                   = '0;
    s.method_candidates = 3'b111;
    s.version_match     = 1'b1;
    return s;
  endfunction

  // Ending a word checks the method and version lengths.
  function automatic scan_t close_word(scan_t s);
    scan_t n;
    n = s;
    if (s.in_word) begin
      n.in_word = 1'b0;
      if (s.word_index == WORD_METHOD) begin
        if (s.char_pos != LEN_GET)    n.method_candidates[0] = 1'b0;
        if (s.char_pos != LEN_POST)   n.method_candidates[1] = 1'b0;
        if (s.char_pos != LEN_DELETE) n.method_candidates[2] = 1'b0;
      end else if (s.word_index == WORD_VERSION) begin
        if (s.char_pos != LEN_VERSION) n.version_match = 1'b0;
      end
    end
    return n;
  endfunction

  // One word character against the word that it belongs to.
  function automatic scan_t take_char(scan_t s, logic [7:0] c);
    scan_t      n;
    logic [3:0] p;
    n = s;
    p = s.char_pos;
    if (!s.in_word) begin
      n.in_word  = 1'b1;
      n.char_pos = '0;
      p          = '0;
      if (s.words_seen != 2'd3) begin
        n.word_index = s.words_seen;
        n.words_seen = s.words_seen + 2'd1;
      end else begin
        n.word_index = WORD_EXTRA;
      end
    end
    case (n.word_index)
      WORD_METHOD: begin
        if (!get_char_ok(p, c))    n.method_candidates[0] = 1'b0;
        if (!post_char_ok(p, c))   n.method_candidates[1] = 1'b0;
        if (!delete_char_ok(p, c)) n.method_candidates[2] = 1'b0;
      end
      WORD_PATH: begin
        if (p == '0) begin
          n.path_first_ok = (c == "/");
        end else if (c == s.path_prev_char && (c == "." || c == "/")) begin
          n.path_bad_pair = 1'b1;
        end
        n.path_prev_char = c;
      end
      WORD_VERSION: begin
        if (!version_char_ok(p, c)) n.version_match = 1'b0;
      end
      default: ;
    endcase
    if (n.char_pos != POS_MAX) n.char_pos = n.char_pos + 4'd1;
    return n;
  endfunction

  scan_t      state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  hrlc_out_t  out_r, out_nxt;
  logic       slot_free;

  // A last byte needs the result register; other bytes never wait.
  assign slot_free = !out_valid_r || out_ready;
  assign rd_take   = head.valid && (!head.entry.last || slot_free);

  // Scan step and verdict for the head byte.
  always_comb begin
    scan_t s;
    logic [1:0] kind;
    logic [1:0] verdict;
    s       = state_r;
    kind    = KIND_UNKNOWN;
    verdict = VERDICT_VALID;
    if (!s.line_done) begin
      case (head.entry.cls)
        CLS_EOL: begin
          s           = close_word(s);
          s.line_done = 1'b1;
        end
        CLS_SEP:  s = close_word(s);
        CLS_CHAR: s = take_char(s, head.entry.ch);
        default:  ;
      endcase
    end
    if (head.entry.last) begin
      s = close_word(s);
      if (s.words_seen != 2'd0) begin
        if (s.method_candidates[0]) begin
          kind = KIND_GET;
        end else if (s.method_candidates[1]) begin
          kind = KIND_POST;
        end else if (s.method_candidates[2]) begin
          kind = KIND_DELETE;
        end
      end
      if (s.words_seen != 2'd3) begin
        verdict = VERDICT_BAD;
      end else if (kind == KIND_UNKNOWN) begin
        verdict = VERDICT_METHOD;
      end else if (!s.version_match) begin
        verdict = VERDICT_VERSION;
      end else if (!s.path_first_ok || s.path_bad_pair) begin
        verdict = VERDICT_BAD;
      end
      s = scan_reset();
    end
    state_nxt           = rd_take ? s : state_r;
    out_nxt.verdict     = verdict;
    out_nxt.method_kind = kind;
    if (rd_take && head.entry.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scan_reset();
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads only when a verdict is formed.
  always_ff @(posedge clk) begin
    if (rd_take && head.entry.last) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
